// File: rtl/core/hpp_pkg.sv
package hpp_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // register fields
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned FACTOR_W  = 8;
  localparam int unsigned FRAC_BITS = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HYST_LENGTH = 2'd0,
    REG_HYST_FACTOR = 2'd1
  } reg_index_t;

  // reset values and legal floor of the factor (1.0 in Q4.4)
  localparam logic [LEN_W-1:0]    HYST_LENGTH_RST = 12'd10;
  localparam logic [FACTOR_W-1:0] HYST_FACTOR_RST = 8'd32;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE      = 8'd16;

endpackage

// File: rtl/core/hysteresis_peak_picker_unit.sv
// an accepted sample word passes the input register, then the result register,
//   on its way to its result word
// throughput: one sample word per cycle, sustained, with no stall on results
// a word that yields no peak and is not the frame's last gives no result
// reset (rst, synchronous, active high) clears the tracker state, drops
//   any word in flight and restores hyst_length 10 and hyst_factor 2.0
module hysteresis_peak_picker_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_FRAME   = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [hpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpp_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  logic                           samp_valid,
  output logic                           samp_stall,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic                           first,
  input  logic                           last,
  // result channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [$clog2(MAX_FRAME)-1:0]   peak_index,
  output logic [SAMPLE_BITS-1:0]         peak_value,
  output logic                           peak_found,
  output logic                           frame_done
);
  import hpp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_FRAME);
  localparam int unsigned LIM_W  = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
  localparam int unsigned PROD_W = SAMPLE_BITS + FACTOR_W;
  localparam logic [IDX_W-1:0] POS_MAX = IDX_W'(MAX_FRAME - 1);

  // configuration registers
  logic [LEN_W-1:0]    hyst_length;
  logic [FACTOR_W-1:0] hyst_factor;

  // input register
  logic                   in_vld;
  logic [SAMPLE_BITS-1:0] s_q;
  logic                   first_q;
  logic                   last_q;

  // tracker state
  logic [SAMPLE_BITS-1:0] run_max, run_max_next;
  logic [SAMPLE_BITS-1:0] run_min, run_min_next;
  logic [IDX_W-1:0]       max_pos, max_pos_next;
  logic [IDX_W-1:0]       thresh_pos, thresh_pos_next;
  logic                   max_valid, max_valid_next;
  logic                   seeking_max, seeking_max_next;
  logic [IDX_W-1:0]       position, position_next;

  // step results
  logic             found;
  logic             emit;
  logic [IDX_W-1:0] n;
  logic [LIM_W-1:0] limit;
  logic             past_limit;
  logic             below_max;
  logic             above_min;
  logic             advance;
  logic             step;

  // the whole pipe moves unless a result word is held by the sink
  assign advance    = !(res_valid && res_stall);
  assign step       = in_vld && advance;
  // an empty input register still takes a word while the result is held
  assign samp_stall = in_vld && !advance;

  // configuration writes, out-of-range values are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_length <= HYST_LENGTH_RST;
      hyst_factor <= HYST_FACTOR_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_HYST_LENGTH && cfg_data[LEN_W-1:0] != '0) begin
        hyst_length <= cfg_data[LEN_W-1:0];
      end
      if (cfg_index == REG_HYST_FACTOR && cfg_data[FACTOR_W-1:0] > FACTOR_ONE) begin
        hyst_factor <= cfg_data[FACTOR_W-1:0];
      end
    end
  end

  // input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!samp_stall) begin
      in_vld <= samp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!samp_stall && samp_valid) begin
      s_q     <= sample;
      first_q <= first;
      last_q  <= last;
    end
  end

  // frame position of this word, saturating at the frame limit
  assign n          = (position == POS_MAX) ? position : position + 1'b1;
  assign limit      = LIM_W'(thresh_pos) + LIM_W'(hyst_length);
  assign past_limit = LIM_W'(n) > limit;

  // ratio tests as exact products: s < max / f and s > min * f
  assign below_max = (PROD_W'(s_q) * PROD_W'(hyst_factor)) < (PROD_W'(run_max) << FRAC_BITS);
  assign above_min = (PROD_W'(s_q) << FRAC_BITS) > (PROD_W'(run_min) * PROD_W'(hyst_factor));

  always_comb begin
    run_max_next     = run_max;
    run_min_next     = run_min;
    max_pos_next     = max_pos;
    thresh_pos_next  = thresh_pos;
    max_valid_next   = max_valid;
    seeking_max_next = seeking_max;
    position_next    = position;
    found            = 1'b0;

    if (first_q) begin
      // new frame: seed the candidate at position zero
      position_next    = '0;
      run_max_next     = s_q;
      max_pos_next     = '0;
      thresh_pos_next  = '0;
      max_valid_next   = 1'b1;
      run_min_next     = s_q;
      seeking_max_next = 1'b1;
    end else begin
      position_next = n;
      if (seeking_max) begin
        if (s_q > run_max) begin
          // rising: new candidate
          run_max_next    = s_q;
          max_pos_next    = n;
          thresh_pos_next = n;
          max_valid_next  = 1'b1;
          run_min_next    = s_q;
        end else if (below_max && max_pos != '0) begin
          if (past_limit) begin
            if (max_valid) begin
              // candidate stayed wide enough: confirm it
              found            = 1'b1;
              seeking_max_next = 1'b0;
            end else begin
              run_max_next    = s_q;
              max_pos_next    = n;
              thresh_pos_next = n;
              max_valid_next  = 1'b1;
              run_min_next    = s_q;
            end
          end else if (s_q < run_min) begin
            run_min_next = s_q;
          end
        end else begin
          // still above the threshold band
          if (thresh_pos != n - 1'b1) begin
            max_valid_next = 1'b0;
            if (past_limit) begin
              run_max_next    = s_q;
              max_pos_next    = n;
              thresh_pos_next = n;
              max_valid_next  = 1'b1;
              run_min_next    = s_q;
            end
          end else begin
            thresh_pos_next = n;
          end
        end
      end else if (s_q < run_min) begin
        run_min_next = s_q;
      end else if (above_min) begin
        // rise after a peak: back to seeking, threshold restarts at zero
        run_max_next     = s_q;
        max_pos_next     = n;
        thresh_pos_next  = '0;
        run_min_next     = s_q;
        max_valid_next   = 1'b1;
        seeking_max_next = 1'b1;
      end
    end
  end

  assign emit = found || last_q;

  // tracker state register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max     <= '0;
      run_min     <= '0;
      max_pos     <= '0;
      thresh_pos  <= '0;
      max_valid   <= 1'b1;
      seeking_max <= 1'b1;
      position    <= '0;
    end else if (step) begin
      run_max     <= run_max_next;
      run_min     <= run_min_next;
      max_pos     <= max_pos_next;
      thresh_pos  <= thresh_pos_next;
      max_valid   <= max_valid_next;
      seeking_max <= seeking_max_next;
      position    <= position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      peak_index <= found ? max_pos : '0;
      peak_value <= found ? run_max : '0;
      peak_found <= found;
      frame_done <= last_q;
    end
  end

endmodule

// File: rtl/core/hpp_checker.sv
module hpp_checker #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_FRAME   = 4096
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic [$clog2(MAX_FRAME)-1:0] peak_index,
  input logic [SAMPLE_BITS-1:0]       peak_value,
  input logic                         peak_found,
  input logic                         frame_done
);
  import hpp_pkg::*;

  // a held result word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(peak_index) && $stable(peak_value)
      && $stable(peak_found) && $stable(frame_done))
    else $error("result word changed while stalled");

  // no result word right after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid after reset");

  // every result word reports a peak or the frame end
  a_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> peak_found || frame_done)
    else $error("empty result word");

  // without a peak the peak fields are zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !peak_found |-> peak_index == '0 && peak_value == '0)
    else $error("peak fields set without a peak");

  // a candidate at position zero is never confirmed
  a_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && peak_found |-> peak_index != '0)
    else $error("peak confirmed at position zero");

endmodule

bind hysteresis_peak_picker_unit hpp_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .MAX_FRAME  (MAX_FRAME)
) u_hpp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .peak_index(peak_index),
  .peak_value(peak_value),
  .peak_found(peak_found),
  .frame_done(frame_done)
);
